// ===== rtl/core/free_range_allocator_macros.svh =====
// Assertion macros used by the allocator top level.
`ifndef FREE_RANGE_ALLOCATOR_MACROS_SVH
`define FREE_RANGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== rtl/core/fra_pkg.sv =====
// Types, constants and helpers for the free range allocator.
package fra_pkg;

  localparam int FREE_ENTRIES = 32;
  localparam int IDX_W        = $clog2(FREE_ENTRIES);
  localparam int CNT_W        = $clog2(FREE_ENTRIES + 1);
  localparam int ENTRY_W      = 64;
  localparam int CFG_AW       = 3;

  localparam logic [1:0] REQ_RESERVE = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_EXTEND  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_AW-1:0] ADDR_POOL_SIZE = '0;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] extra;
    logic [31:0] alignment;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] granted_length;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_RD, S_EV1, S_EV2, S_WR2, S_FREE_FIN, S_ER_RD, S_ER_WR, S_DONE
  } state_t;

  // Clamp a merged length to the 32-bit range.
  function automatic logic [31:0] sat32(input logic [33:0] v);
    sat32 = (v[33:32] != 2'b00) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

// ===== rtl/core/free_range_allocator.sv =====
// Top level of the first-fit free range allocator.
//
// Usage:
//   Program pool_size through the APB port (byte address 0) while the block
//   is idle; a write clears the free table, which is rebuilt as one range
//   covering the pool on the next reserve or extend.
//   Issue a request by raising start with the request word on in_req; it is
//   taken at an edge where busy is low. busy stays high until the result.
//   Exactly one result word per request appears on out_res for one cycle,
//   flagged by out_valid, in the last cycle that busy is high. The receiver
//   cannot stall, so the word must be captured in that cycle.
// Steps: each table entry scanned goes through a RAM read, then deriving the
//   aligned start and range end, then a decision; lazy setup comes before the
//   scan, a tail append or free update comes after it, and erasing a range
//   adds a read and a write for each entry shifted; early rejects go
//   straight to the result. A new request is taken only once the block is
//   idle again after the result is given.
// Reset: rst_n (synchronous, active low) clears pool size, fill count and
//   setup flag; RAM entries at or above the fill count are never read.
module free_range_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  fra_pkg::req_t             in_req,
  output logic                      busy,
  output logic                      out_valid,
  output fra_pkg::res_t             out_res,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fra_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import fra_pkg::*;
  `include "free_range_allocator_macros.svh"

  state_t            state_r, state_nxt;
  logic [31:0]       pool_r, pool_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ready_r, ready_nxt;
  req_t              req_r, req_nxt;
  logic [32:0]       claim_r, claim_nxt;   // rounded size
  logic [32:0]       end_r, end_nxt;       // offset + length
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [31:0]       s_r, s_nxt, l_r, l_nxt;
  logic [32:0]       a_r, a_nxt, e_r, e_nxt;
  logic              hb_r, hb_nxt, ha_r, ha_nxt;
  logic [IDX_W-1:0]  bi_r, bi_nxt, ai_r, ai_nxt;
  logic [31:0]       sb_r, sb_nxt, lb_r, lb_nxt, sa_r, sa_nxt, la_r, la_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [31:0]       go_r, go_nxt, gl_r, gl_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  logic        accept, cfg_wr;
  logic [31:0] am1;
  logic [32:0] mask33, avail, rnd_sum;
  logic [CNT_W-1:0] idx_inc;
  logic        last, hbm, ham;

  fra_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_POOL_SIZE) ? pool_r : 32'd0;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_res   = '{status: st_r, granted_offset: go_r, granted_length: gl_r};

  // Alignment mask: upper bit always kept, so 33-bit results compare whole.
  assign am1     = req_r.alignment - 32'd1;
  assign mask33  = {1'b1, ~am1};
  assign rnd_sum = {1'b0, in_req.length} + {1'b0, in_req.alignment - 32'd1};
  assign avail   = e_r - a_r;
  assign idx_inc = idx_r + CNT_W'(1);
  assign last    = (idx_inc >= cnt_r);
  assign hbm     = (e_r == {1'b0, req_r.offset});
  assign ham     = ({1'b0, s_r} == end_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req.req_type)
            REQ_RESERVE: begin
              if (in_req.length > pool_r) state_nxt = S_DONE;
              else if (!ready_r)          state_nxt = S_INIT;
              else if (cnt_r == '0)       state_nxt = S_DONE;
              else                        state_nxt = S_RD;
            end
            REQ_FREE: begin
              if (in_req.length == 32'd0 || !ready_r) state_nxt = S_DONE;
              else if (cnt_r == '0)                   state_nxt = S_FREE_FIN;
              else                                    state_nxt = S_RD;
            end
            REQ_EXTEND: begin
              if (in_req.extra > pool_r) state_nxt = S_DONE;
              else if (!ready_r)         state_nxt = S_INIT;
              else if (cnt_r == '0)      state_nxt = S_DONE;
              else                       state_nxt = S_RD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_INIT: state_nxt = S_RD;
      S_RD:   state_nxt = S_EV1;
      S_EV1:  state_nxt = S_EV2;
      S_EV2: begin
        case (req_r.req_type)
          REQ_RESERVE: begin
            if (a_r == {1'b0, s_r}) begin
              if ({1'b0, l_r} > claim_r)       state_nxt = S_DONE;
              else if ({1'b0, l_r} == claim_r) state_nxt = S_ER_RD;
              else if (last)                   state_nxt = S_DONE;
              else                             state_nxt = S_RD;
            end else if (a_r <= e_r && avail >= claim_r) begin
              if (avail == claim_r)                       state_nxt = S_DONE;
              else if (cnt_r >= CNT_W'(FREE_ENTRIES))     state_nxt = S_DONE;
              else                                        state_nxt = S_WR2;
            end else if (last) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RD;
            end
          end
          REQ_FREE: begin
            if (((hb_r || hbm) && (ha_r || ham)) || last) state_nxt = S_FREE_FIN;
            else                                          state_nxt = S_RD;
          end
          default: begin
            if (ham && l_r == req_r.extra)     state_nxt = S_ER_RD;
            else if (ham && l_r > req_r.extra) state_nxt = S_DONE;
            else if (last)                     state_nxt = S_DONE;
            else                               state_nxt = S_RD;
          end
        endcase
      end
      S_WR2: state_nxt = S_DONE;
      S_FREE_FIN: state_nxt = (hb_r && ha_r) ? S_ER_RD : S_DONE;
      S_ER_RD: state_nxt = last ? S_DONE : S_ER_WR;
      S_ER_WR: state_nxt = S_ER_RD;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    pool_nxt  = pool_r;   cnt_nxt  = cnt_r;   ready_nxt = ready_r;
    req_nxt   = req_r;    claim_nxt = claim_r; end_nxt = end_r;
    idx_nxt   = idx_r;    s_nxt    = s_r;     l_nxt    = l_r;
    a_nxt     = a_r;      e_nxt    = e_r;
    hb_nxt    = hb_r;     ha_nxt   = ha_r;    bi_nxt   = bi_r;  ai_nxt = ai_r;
    sb_nxt    = sb_r;     lb_nxt   = lb_r;    sa_nxt   = sa_r;  la_nxt = la_r;
    st_nxt    = st_r;     go_nxt   = go_r;    gl_nxt   = gl_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r[IDX_W-1:0];
    ram_wdata = '0;
    ram_raddr = idx_r[IDX_W-1:0];

    // Config writes must come only while idle; the block does not enforce it. A pool write clears the table.
    if (cfg_wr && paddr == ADDR_POOL_SIZE) begin
      pool_nxt  = pwdata;
      cnt_nxt   = '0;
      ready_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_req;
          end_nxt   = {1'b0, in_req.offset} + {1'b0, in_req.length};
          claim_nxt = (in_req.alignment == 32'd0) ? {1'b0, in_req.length}
                    : (rnd_sum & {1'b1, ~(in_req.alignment - 32'd1)});
          idx_nxt = '0;
          hb_nxt  = 1'b0;
          ha_nxt  = 1'b0;
          go_nxt  = '0;
          gl_nxt  = '0;
          st_nxt  = ST_DONE;
          case (in_req.req_type)
            REQ_RESERVE: begin
              if (in_req.length > pool_r || (ready_r && cnt_r == '0)) st_nxt = ST_NOFIT;
            end
            REQ_FREE: st_nxt = ST_DONE;
            REQ_EXTEND: begin
              if (in_req.extra > pool_r || (ready_r && cnt_r == '0)) st_nxt = ST_NOFIT;
            end
            default: st_nxt = ST_NOFIT;
          endcase
        end
      end
      S_INIT: begin
        // Lazy setup: one range over the whole pool.
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {32'd0, pool_r};
        cnt_nxt   = CNT_W'(1);
        ready_nxt = 1'b1;
      end
      S_RD: ram_raddr = idx_r[IDX_W-1:0];
      S_EV1: begin
        s_nxt = ram_rdata[63:32];
        l_nxt = ram_rdata[31:0];
        e_nxt = {1'b0, ram_rdata[63:32]} + {1'b0, ram_rdata[31:0]};
        a_nxt = (req_r.alignment == 32'd0) ? {1'b0, ram_rdata[63:32]}
              : (({1'b0, ram_rdata[63:32]} + {1'b0, am1}) & mask33);
      end
      S_EV2: begin
        case (req_r.req_type)
          REQ_RESERVE: begin
            if (a_r == {1'b0, s_r} && {1'b0, l_r} >= claim_r) begin
              go_nxt = s_r;
              gl_nxt = claim_r[31:0];
              if ({1'b0, l_r} > claim_r) begin
                ram_we    = 1'b1;
                ram_wdata = {s_r + claim_r[31:0], l_r - claim_r[31:0]};
              end
            end else if (a_r != {1'b0, s_r} && a_r <= e_r && avail >= claim_r) begin
              if (avail != claim_r && cnt_r >= CNT_W'(FREE_ENTRIES)) begin
                st_nxt = ST_FULL;
              end else begin
                // Keep the leading gap in place; remainder goes in WR2.
                go_nxt    = a_r[31:0];
                gl_nxt    = claim_r[31:0];
                ram_we    = 1'b1;
                ram_wdata = {s_r, a_r[31:0] - s_r};
              end
            end else if (last) begin
              st_nxt = ST_NOFIT;
            end else begin
              idx_nxt = idx_inc;
            end
          end
          REQ_FREE: begin
            if (hbm) begin
              hb_nxt = 1'b1;
              bi_nxt = idx_r[IDX_W-1:0];
              sb_nxt = s_r;
              lb_nxt = l_r;
            end
            if (ham) begin
              ha_nxt = 1'b1;
              ai_nxt = idx_r[IDX_W-1:0];
              sa_nxt = s_r;
              la_nxt = l_r;
            end
            idx_nxt = idx_inc;
          end
          default: begin
            if (ham && l_r > req_r.extra) begin
              ram_we    = 1'b1;
              ram_wdata = {s_r + req_r.extra, l_r - req_r.extra};
            end else if (!(ham && l_r == req_r.extra)) begin
              if (last) st_nxt = ST_NOFIT;
              else      idx_nxt = idx_inc;
            end
          end
        endcase
      end
      S_WR2: begin
        // Append the tail left after the aligned block.
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IDX_W-1:0];
        ram_wdata = {a_r[31:0] + claim_r[31:0], avail[31:0] - claim_r[31:0]};
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
      S_FREE_FIN: begin
        if (hb_r && ha_r) begin
          ram_we    = 1'b1;
          ram_waddr = bi_r;
          ram_wdata = {sb_r, sat32({2'b00, lb_r} + {2'b00, req_r.length} + {2'b00, la_r})};
          idx_nxt   = {{(CNT_W-IDX_W){1'b0}}, ai_r};
        end else if (hb_r) begin
          ram_we    = 1'b1;
          ram_waddr = bi_r;
          ram_wdata = {sb_r, sat32({2'b00, lb_r} + {2'b00, req_r.length})};
        end else if (ha_r) begin
          ram_we    = 1'b1;
          ram_waddr = ai_r;
          ram_wdata = {sa_r - req_r.length, sat32({2'b00, la_r} + {2'b00, req_r.length})};
        end else if (cnt_r >= CNT_W'(FREE_ENTRIES)) begin
          st_nxt = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r[IDX_W-1:0];
          ram_wdata = {req_r.offset, req_r.length};
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
      end
      S_ER_RD: begin
        // Shift the entries above down by one, then drop the count.
        if (last) cnt_nxt = cnt_r - CNT_W'(1);
        else      ram_raddr = idx_inc[IDX_W-1:0];
      end
      S_ER_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_inc;
      end
      S_DONE: begin
        // Result words carry zero offset and length unless a grant succeeded.
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pool_r  <= '0;
      cnt_r   <= '0;
      ready_r <= 1'b0;
      hb_r    <= 1'b0;
      ha_r    <= 1'b0;
      st_r    <= ST_DONE;
      go_r    <= '0;
      gl_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pool_r  <= pool_nxt;
      cnt_r   <= cnt_nxt;
      ready_r <= ready_nxt;
      hb_r    <= hb_nxt;
      ha_r    <= ha_nxt;
      st_r    <= st_nxt;
      go_r    <= (st_nxt == ST_DONE) ? go_nxt : 32'd0;
      gl_r    <= (st_nxt == ST_DONE) ? gl_nxt : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    claim_r <= claim_nxt;
    end_r   <= end_nxt;
    idx_r   <= idx_nxt;
    s_r     <= s_nxt;
    l_r     <= l_nxt;
    a_r     <= a_nxt;
    e_r     <= e_nxt;
    bi_r    <= bi_nxt;
    ai_r    <= ai_nxt;
    sb_r    <= sb_nxt;
    lb_r    <= lb_nxt;
    sa_r    <= sa_nxt;
    la_r    <= la_nxt;
  end

  `FRA_ASSERT_NXT(a_one_result, out_valid, !out_valid && !busy)
  `FRA_ASSERT_NXT(a_take_busy, accept, busy)
  `FRA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(FREE_ENTRIES))
  `FRA_ASSERT_IMP(a_zero_on_fail, out_valid && out_res.status != ST_DONE,
                  out_res.granted_offset == 32'd0 && out_res.granted_length == 32'd0)
endmodule

// ===== rtl/core/fra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
